// File: hdl/mips_integer_instruction_execute_defines.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef MIPS_INTEGER_INSTRUCTION_EXECUTE_DEFINES_SVH
`define MIPS_INTEGER_INSTRUCTION_EXECUTE_DEFINES_SVH

// Same-cycle property.
`define MIE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent now, consequent in the next cycle.
`define MIE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mie_pkg.sv
package mie_pkg;

  localparam int unsigned MEM_WORDS = 1024;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
  localparam int unsigned GPR_COUNT = 32;
  localparam int unsigned GPR_AW    = $clog2(GPR_COUNT);

  localparam logic [31:0] START_PC_RESET = 32'hA000_0000;
  localparam logic [31:0] JUMP_REGION    = 32'hF000_0000;

  typedef enum logic [5:0] {
    OP_SPECIAL = 6'd0,
    OP_REGIMM  = 6'd1,
    OP_J       = 6'd2,
    OP_JAL     = 6'd3,
    OP_BEQ     = 6'd4,
    OP_BNE     = 6'd5,
    OP_BLEZ    = 6'd6,
    OP_BGTZ    = 6'd7,
    OP_ADDIU   = 6'd9,
    OP_SLTI    = 6'd10,
    OP_SLTIU   = 6'd11,
    OP_ANDI    = 6'd12,
    OP_ORI     = 6'd13,
    OP_XORI    = 6'd14,
    OP_LUI     = 6'd15,
    OP_COP0    = 6'd16,
    OP_LB      = 6'd32,
    OP_LW      = 6'd35,
    OP_LBU     = 6'd36,
    OP_SB      = 6'd40,
    OP_SW      = 6'd43
  } opcode_e;

  typedef enum logic [5:0] {
    FN_SLL  = 6'd0,
    FN_SRL  = 6'd2,
    FN_SRA  = 6'd3,
    FN_SLLV = 6'd4,
    FN_SRLV = 6'd6,
    FN_SRAV = 6'd7,
    FN_JR   = 6'd8,
    FN_JALR = 6'd9,
    FN_MFHI = 6'd16,
    FN_MTHI = 6'd17,
    FN_MFLO = 6'd18,
    FN_MTLO = 6'd19,
    FN_MULT = 6'd24,
    FN_ADDU = 6'd33,
    FN_SUBU = 6'd35,
    FN_AND  = 6'd36,
    FN_OR   = 6'd37,
    FN_XOR  = 6'd38,
    FN_NOR  = 6'd39,
    FN_SLT  = 6'd42,
    FN_SLTU = 6'd43
  } funct_e;

  typedef enum logic [4:0] {
    RI_BLTZ = 5'd0,
    RI_BGEZ = 5'd1
  } regimm_e;

  typedef enum logic [4:0] {
    CP_MF = 5'd0,
    CP_MT = 5'd4
  } cop_e;

  typedef enum logic [1:0] {
    STORE_NONE = 2'd0,
    STORE_WORD = 2'd1,
    STORE_BYTE = 2'd2
  } store_kind_e;

  typedef enum logic [1:0] {
    LD_WORD  = 2'd0,
    LD_BYTE  = 2'd1,
    LD_UBYTE = 2'd2
  } load_kind_e;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [1:0]  store_kind;
    logic [31:0] store_address;
    logic [31:0] store_value;
    logic [31:0] hi_value;
    logic [31:0] lo_value;
  } result_t;

endpackage

// File: hdl/mie_intf.sv
interface mie_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_pc;
  modport source (output valid, output start_pc, input ready);
  modport sink (input valid, input start_pc, output ready);
endinterface

interface mie_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

interface mie_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        reg_write;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic [1:0]  store_kind;
  logic [31:0] store_address;
  logic [31:0] store_value;
  logic [31:0] hi_value;
  logic [31:0] lo_value;
  modport source (
    output valid, output next_pc, output reg_write, output reg_index, output reg_value,
    output store_kind, output store_address, output store_value, output hi_value,
    output lo_value, input ready
  );
  modport sink (
    input valid, input next_pc, input reg_write, input reg_index, input reg_value,
    input store_kind, input store_address, input store_value, input hi_value,
    input lo_value, output ready
  );
endinterface

// File: hdl/mie_ram.sv
module mie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [WIDTH/8-1:0]       be_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int i = 0; i < WIDTH / 8; i++) begin
        if (be_i[i]) begin
          mem_q[waddr_i][i*8 +: 8] <= wdata_i[i*8 +: 8];
        end
      end
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/mips_integer_instruction_execute.sv
// Pipeline: an accepted instruction passes the ex, mem and out registers before its
// result is valid. Throughput: one instruction per cycle outside the memory clear;
// the pipeline holds only while the receiver keeps a finished result waiting.
// Reset: pc = start_pc reset value, registers, hi/lo and cp0 cleared; then a
// pass over every data memory word zeroes it, during which no instruction is taken.
`include "mips_integer_instruction_execute_defines.svh"

module mips_integer_instruction_execute
  import mie_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  mie_cfg_if.sink      cfg_i,
  mie_instr_if.sink    instr_i,
  mie_result_if.source result_o
);

  typedef struct packed {
    logic [31:0] next_pc;
    logic        wr;
    logic [4:0]  idx;
    logic [31:0] val;
    logic        is_load;
    logic [1:0]  ld_kind;
    logic [1:0]  boff;
    logic [1:0]  skind;
    logic [31:0] saddr;
    logic [31:0] sval;
    logic [31:0] hi;
    logic [31:0] lo;
    logic        is_mult;
  } mem_t;

  // control
  logic              clr_busy_q;
  logic [MEM_AW-1:0] clr_cnt_q;
  logic              ex_v_q, mem_v_q, out_v_q;
  logic              wb_v_q;
  logic              in_acc, ex_moves, mem_moves;

  // architectural
  logic [31:0] pc_q, hi_q, lo_q;
  logic [31:0] cp0_q [32];
  logic [GPR_COUNT-1:0] gv_q;

  // pipeline payload
  logic [31:0] ex_ins_q;
  logic        ga_v_q, gb_v_q, col_a_q, col_b_q;
  logic [31:0] col_a_val_q, col_b_val_q;
  mem_t        mem_q, mem_d;
  logic [63:0] prod_q, prod_d;
  result_t     out_q, out_d;
  logic [GPR_AW-1:0] wb_idx_q;
  logic [31:0] wb_val_q;

  // ram signals
  logic [31:0] ram_a_rdata, ram_b_rdata, dmem_rdata;
  logic        gpr_we;
  logic [GPR_AW-1:0] gpr_widx;
  logic [31:0] gpr_wval;
  logic        dmem_we, dmem_re;
  logic [3:0]  dmem_be, st_be;
  logic [MEM_AW-1:0] dmem_waddr, ex_word;
  logic [31:0] dmem_wdata, st_data;

  // execute stage
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [31:0] a, b, imm_s, imm_z, pc4, btarget, jtarget, addr;
  logic [31:0] hi_eff, lo_eff, mem_hi_fin, lo_fin;
  logic [31:0] mem_val_fin, lane;
  logic        mtc0;

  assign in_acc    = instr_i.valid && instr_i.ready;
  assign mem_moves = mem_v_q && (!out_v_q || result_o.ready);
  assign ex_moves  = ex_v_q && (!mem_v_q || mem_moves);
  assign instr_i.ready = !clr_busy_q && (!ex_v_q || ex_moves);
  assign cfg_i.ready   = 1'b1;

  assign gpr_we   = mem_moves && mem_q.wr;
  assign gpr_widx = mem_q.idx;
  assign gpr_wval = mem_val_fin;

  mie_ram #(.WIDTH(32), .DEPTH(GPR_COUNT)) u_gpr_a (
    .clk_i, .we_i(gpr_we), .be_i(4'hF), .waddr_i(gpr_widx), .wdata_i(gpr_wval),
    .re_i(in_acc), .raddr_i(instr_i.instruction[25:21]), .rdata_o(ram_a_rdata)
  );

  mie_ram #(.WIDTH(32), .DEPTH(GPR_COUNT)) u_gpr_b (
    .clk_i, .we_i(gpr_we), .be_i(4'hF), .waddr_i(gpr_widx), .wdata_i(gpr_wval),
    .re_i(in_acc), .raddr_i(instr_i.instruction[20:16]), .rdata_o(ram_b_rdata)
  );

  assign dmem_we    = clr_busy_q || (ex_moves && (op == OP_SW || op == OP_SB));
  assign dmem_be    = clr_busy_q ? 4'hF : st_be;
  assign dmem_waddr = clr_busy_q ? clr_cnt_q : ex_word;
  assign dmem_wdata = clr_busy_q ? '0 : st_data;
  assign dmem_re    = ex_moves && (op == OP_LW || op == OP_LB || op == OP_LBU);

  mie_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
    .clk_i, .we_i(dmem_we), .be_i(dmem_be), .waddr_i(dmem_waddr), .wdata_i(dmem_wdata),
    .re_i(dmem_re), .raddr_i(ex_word), .rdata_o(dmem_rdata)
  );

  assign op = ex_ins_q[31:26];
  assign fn = ex_ins_q[5:0];
  assign rs = ex_ins_q[25:21];
  assign rt = ex_ins_q[20:16];
  assign rd = ex_ins_q[15:11];
  assign sa = ex_ins_q[10:6];

  // operand forwarding: mem stage (load data included), last write, same-edge write, ram
  always_comb begin
    if (mem_v_q && mem_q.wr && mem_q.idx == rs) begin
      a = mem_val_fin;
    end else if (wb_v_q && wb_idx_q == rs) begin
      a = wb_val_q;
    end else if (col_a_q) begin
      a = col_a_val_q;
    end else if (ga_v_q) begin
      a = ram_a_rdata;
    end else begin
      a = '0;
    end
    if (mem_v_q && mem_q.wr && mem_q.idx == rt) begin
      b = mem_val_fin;
    end else if (wb_v_q && wb_idx_q == rt) begin
      b = wb_val_q;
    end else if (col_b_q) begin
      b = col_b_val_q;
    end else if (gb_v_q) begin
      b = ram_b_rdata;
    end else begin
      b = '0;
    end
  end

  assign mem_hi_fin = mem_q.is_mult ? prod_q[63:32] : mem_q.hi;
  assign lo_fin     = mem_q.is_mult ? prod_q[31:0] : mem_q.lo;
  assign hi_eff     = mem_v_q ? mem_hi_fin : hi_q;
  assign lo_eff     = mem_v_q ? lo_fin : lo_q;

  assign imm_s   = {{16{ex_ins_q[15]}}, ex_ins_q[15:0]};
  assign imm_z   = {16'h0000, ex_ins_q[15:0]};
  assign pc4     = pc_q + 32'd4;
  assign btarget = pc4 + {imm_s[29:0], 2'b00};
  assign jtarget = (pc4 & JUMP_REGION) | {4'h0, ex_ins_q[25:0], 2'b00};
  assign addr    = a + imm_s;
  assign ex_word = addr[MEM_AW+1:2];
  assign st_be   = (op == OP_SB) ? (4'b0001 << addr[1:0]) : 4'hF;
  assign st_data = (op == OP_SB) ? {4{b[7:0]}} : b;
  assign mtc0    = op == OP_COP0 && rs == CP_MT;
  assign prod_d  = 64'($signed(a) * $signed(b));

  always_comb begin
    mem_d         = '0;
    mem_d.next_pc = pc4;
    mem_d.idx     = rd;
    mem_d.hi      = hi_eff;
    mem_d.lo      = lo_eff;
    mem_d.boff    = addr[1:0];
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL:  begin mem_d.wr = 1'b1; mem_d.val = b << sa; end
          FN_SRL:  begin mem_d.wr = 1'b1; mem_d.val = b >> sa; end
          FN_SRA:  begin mem_d.wr = 1'b1; mem_d.val = 32'($signed(b) >>> sa); end
          FN_SLLV: begin mem_d.wr = 1'b1; mem_d.val = b << a[4:0]; end
          FN_SRLV: begin mem_d.wr = 1'b1; mem_d.val = b >> a[4:0]; end
          FN_SRAV: begin mem_d.wr = 1'b1; mem_d.val = 32'($signed(b) >>> a[4:0]); end
          FN_JR:   mem_d.next_pc = a;
          FN_JALR: begin mem_d.wr = 1'b1; mem_d.val = pc4; mem_d.next_pc = a; end
          FN_MFHI: begin mem_d.wr = 1'b1; mem_d.val = hi_eff; end
          FN_MTHI: mem_d.hi = a;
          FN_MFLO: begin mem_d.wr = 1'b1; mem_d.val = lo_eff; end
          FN_MTLO: mem_d.lo = a;
          FN_MULT: mem_d.is_mult = 1'b1;
          FN_ADDU: begin mem_d.wr = 1'b1; mem_d.val = a + b; end
          FN_SUBU: begin mem_d.wr = 1'b1; mem_d.val = a - b; end
          FN_AND:  begin mem_d.wr = 1'b1; mem_d.val = a & b; end
          FN_OR:   begin mem_d.wr = 1'b1; mem_d.val = a | b; end
          FN_XOR:  begin mem_d.wr = 1'b1; mem_d.val = a ^ b; end
          FN_NOR:  begin mem_d.wr = 1'b1; mem_d.val = ~(a | b); end
          FN_SLT:  begin
            mem_d.wr = 1'b1; mem_d.val = {31'd0, $signed(a) < $signed(b)};
          end
          FN_SLTU: begin mem_d.wr = 1'b1; mem_d.val = {31'd0, a < b}; end
          default: ;
        endcase
      end
      OP_REGIMM: begin
        if ((rt == RI_BLTZ && a[31]) || (rt == RI_BGEZ && !a[31])) begin
          mem_d.next_pc = btarget;
        end
      end
      OP_J:    mem_d.next_pc = jtarget;
      OP_JAL:  begin
        mem_d.wr = 1'b1; mem_d.idx = 5'd31; mem_d.val = pc4; mem_d.next_pc = jtarget;
      end
      OP_BEQ:  if (a == b) mem_d.next_pc = btarget;
      OP_BNE:  if (a != b) mem_d.next_pc = btarget;
      OP_BLEZ: if (a[31] || a == '0) mem_d.next_pc = btarget;
      OP_BGTZ: if (!a[31] && a != '0) mem_d.next_pc = btarget;
      OP_ADDIU: begin mem_d.wr = 1'b1; mem_d.idx = rt; mem_d.val = addr; end
      OP_SLTI: begin
        mem_d.wr = 1'b1; mem_d.idx = rt; mem_d.val = {31'd0, $signed(a) < $signed(imm_s)};
      end
      OP_SLTIU: begin mem_d.wr = 1'b1; mem_d.idx = rt; mem_d.val = {31'd0, a < imm_s}; end
      OP_ANDI: begin mem_d.wr = 1'b1; mem_d.idx = rt; mem_d.val = a & imm_z; end
      OP_ORI:  begin mem_d.wr = 1'b1; mem_d.idx = rt; mem_d.val = a | imm_z; end
      OP_XORI: begin mem_d.wr = 1'b1; mem_d.idx = rt; mem_d.val = a ^ imm_z; end
      OP_LUI:  begin mem_d.wr = 1'b1; mem_d.idx = rt; mem_d.val = {ex_ins_q[15:0], 16'h0000}; end
      OP_COP0: begin
        if (rs == CP_MF) begin
          mem_d.wr = 1'b1; mem_d.idx = rt; mem_d.val = cp0_q[rd];
        end
      end
      OP_LB: begin
        mem_d.wr = 1'b1; mem_d.idx = rt; mem_d.is_load = 1'b1; mem_d.ld_kind = LD_BYTE;
      end
      OP_LW: begin
        mem_d.wr = 1'b1; mem_d.idx = rt; mem_d.is_load = 1'b1; mem_d.ld_kind = LD_WORD;
      end
      OP_LBU: begin
        mem_d.wr = 1'b1; mem_d.idx = rt; mem_d.is_load = 1'b1; mem_d.ld_kind = LD_UBYTE;
      end
      OP_SB: begin
        mem_d.skind = STORE_BYTE; mem_d.saddr = addr; mem_d.sval = {24'd0, b[7:0]};
      end
      OP_SW: begin mem_d.skind = STORE_WORD; mem_d.saddr = addr; mem_d.sval = b; end
      default: ;
    endcase
    if (!mem_d.wr || mem_d.idx == '0) begin
      mem_d.wr      = 1'b0;
      mem_d.idx     = '0;
      mem_d.val     = '0;
      mem_d.is_load = 1'b0;
    end
  end

  // load data alignment
  assign lane = dmem_rdata >> {mem_q.boff, 3'b000};
  always_comb begin
    mem_val_fin = mem_q.val;
    if (mem_q.is_load) begin
      case (mem_q.ld_kind)
        LD_BYTE:  mem_val_fin = {{24{lane[7]}}, lane[7:0]};
        LD_UBYTE: mem_val_fin = {24'd0, lane[7:0]};
        default:  mem_val_fin = dmem_rdata;
      endcase
    end
  end

  always_comb begin
    out_d.next_pc       = mem_q.next_pc;
    out_d.reg_write     = mem_q.wr;
    out_d.reg_index     = mem_q.idx;
    out_d.reg_value     = mem_val_fin;
    out_d.store_kind    = mem_q.skind;
    out_d.store_address = mem_q.saddr;
    out_d.store_value   = mem_q.sval;
    out_d.hi_value      = mem_hi_fin;
    out_d.lo_value      = lo_fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      ex_v_q     <= 1'b0;
      mem_v_q    <= 1'b0;
      out_v_q    <= 1'b0;
      wb_v_q     <= 1'b0;
      gv_q       <= '0;
      pc_q       <= START_PC_RESET;
      hi_q       <= '0;
      lo_q       <= '0;
      for (int i = 0; i < 32; i++) begin
        cp0_q[i] <= '0;
      end
    end else begin
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == MEM_AW'(MEM_WORDS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (in_acc) begin
        ex_v_q <= 1'b1;
      end else if (ex_moves) begin
        ex_v_q <= 1'b0;
      end
      if (ex_moves) begin
        mem_v_q <= 1'b1;
      end else if (mem_moves) begin
        mem_v_q <= 1'b0;
      end
      if (mem_moves) begin
        out_v_q <= 1'b1;
        hi_q    <= mem_hi_fin;
        lo_q    <= lo_fin;
      end else if (result_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (gpr_we) begin
        wb_v_q         <= 1'b1;
        gv_q[gpr_widx] <= 1'b1;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        pc_q <= cfg_i.start_pc;
      end else if (ex_moves) begin
        pc_q <= mem_d.next_pc;
      end
      if (ex_moves && mtc0) begin
        cp0_q[rd] <= b;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ex_ins_q    <= instr_i.instruction;
      ga_v_q      <= gv_q[instr_i.instruction[25:21]];
      gb_v_q      <= gv_q[instr_i.instruction[20:16]];
      col_a_q     <= gpr_we && gpr_widx == instr_i.instruction[25:21];
      col_b_q     <= gpr_we && gpr_widx == instr_i.instruction[20:16];
      col_a_val_q <= gpr_wval;
      col_b_val_q <= gpr_wval;
    end
    if (ex_moves) begin
      mem_q  <= mem_d;
      prod_q <= prod_d;
    end
    if (mem_moves) begin
      out_q <= out_d;
    end
    if (gpr_we) begin
      wb_idx_q <= gpr_widx;
      wb_val_q <= gpr_wval;
    end
  end

  assign result_o.valid         = out_v_q;
  assign result_o.next_pc       = out_q.next_pc;
  assign result_o.reg_write     = out_q.reg_write;
  assign result_o.reg_index     = out_q.reg_index;
  assign result_o.reg_value     = out_q.reg_value;
  assign result_o.store_kind    = out_q.store_kind;
  assign result_o.store_address = out_q.store_address;
  assign result_o.store_value   = out_q.store_value;
  assign result_o.hi_value      = out_q.hi_value;
  assign result_o.lo_value      = out_q.lo_value;

  `MIE_ASSERT_NEXT(a_out_hold, out_v_q && !result_o.ready, out_v_q, "result dropped while held")
  `MIE_ASSERT(a_no_accept_in_clear, clr_busy_q |-> !instr_i.ready, "accept during clear")
  `MIE_ASSERT(a_no_zero_write, gpr_we |-> (gpr_widx != '0), "write to register zero")
  `MIE_ASSERT_NEXT(a_ex_to_mem, ex_moves, mem_v_q, "instruction lost between stages")

endmodule

// File: dv/mie_tb_pkg.sv
package mie_tb_pkg;
  import mie_pkg::*;

  class mips_exec_scoreboard;
    logic [31:0] start_pc;
    logic [31:0] pc;
    logic [31:0] gpr [32];
    logic [31:0] cp0 [32];
    logic [31:0] dmem [MEM_WORDS];
    logic [31:0] hi;
    logic [31:0] lo;
    result_t     pending_results[$];
    int          mismatches;

    function new();
      mismatches = 0;
      clear_state();
    endfunction

    function void clear_state();
      start_pc = START_PC_RESET;
      pc = start_pc;
      hi = '0;
      lo = '0;
      foreach (gpr[i]) gpr[i] = '0;
      foreach (cp0[i]) cp0[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
    endfunction

    function void write_start_pc(logic [31:0] v);
      start_pc = v;
      pc = v;
    endfunction

    function logic [31:0] sx16(logic [15:0] v);
      return {{16{v[15]}}, v};
    endfunction

    function void note_instruction(logic [31:0] ins);
      logic [5:0]  op;
      logic [5:0]  fn;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  rd;
      logic [4:0]  sa;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] pc4;
      logic [31:0] npc;
      logic [31:0] btgt;
      logic [31:0] addr;
      logic [31:0] widx;
      logic [63:0] prod;
      logic [4:0]  sh;
      logic        wr;
      logic [4:0]  wi;
      logic [31:0] wv;
      result_t     r;
      op = ins[31:26];
      fn = ins[5:0];
      rs = ins[25:21];
      rt = ins[20:16];
      rd = ins[15:11];
      sa = ins[10:6];
      a = (rs == 0) ? '0 : gpr[rs];
      b = (rt == 0) ? '0 : gpr[rt];
      pc4 = pc + 32'd4;
      npc = pc4;
      btgt = pc4 + (sx16(ins[15:0]) << 2);
      addr = a + sx16(ins[15:0]);
      widx = (addr >> 2) % MEM_WORDS;
      sh = {addr[1:0], 3'b000};
      wr = 1'b0;
      wi = '0;
      wv = '0;
      r = '0;
      case (op)
        OP_SPECIAL: begin
          case (fn)
            FN_SLL: begin wr = 1; wi = rd; wv = b << sa; end
            FN_SRL: begin wr = 1; wi = rd; wv = b >> sa; end
            FN_SRA: begin wr = 1; wi = rd; wv = $signed(b) >>> sa; end
            FN_SLLV: begin wr = 1; wi = rd; wv = b << a[4:0]; end
            FN_SRLV: begin wr = 1; wi = rd; wv = b >> a[4:0]; end
            FN_SRAV: begin wr = 1; wi = rd; wv = $signed(b) >>> a[4:0]; end
            FN_JR: npc = a;
            FN_JALR: begin wr = 1; wi = rd; wv = pc4; npc = a; end
            FN_MFHI: begin wr = 1; wi = rd; wv = hi; end
            FN_MTHI: hi = a;
            FN_MFLO: begin wr = 1; wi = rd; wv = lo; end
            FN_MTLO: lo = a;
            FN_MULT: begin
              prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
              hi = prod[63:32];
              lo = prod[31:0];
            end
            FN_ADDU: begin wr = 1; wi = rd; wv = a + b; end
            FN_SUBU: begin wr = 1; wi = rd; wv = a - b; end
            FN_AND: begin wr = 1; wi = rd; wv = a & b; end
            FN_OR: begin wr = 1; wi = rd; wv = a | b; end
            FN_XOR: begin wr = 1; wi = rd; wv = a ^ b; end
            FN_NOR: begin wr = 1; wi = rd; wv = ~(a | b); end
            FN_SLT: begin wr = 1; wi = rd; wv = {31'd0, $signed(a) < $signed(b)}; end
            FN_SLTU: begin wr = 1; wi = rd; wv = {31'd0, a < b}; end
            default: ;
          endcase
        end
        OP_REGIMM: begin
          if (rt == RI_BLTZ && a[31]) npc = btgt;
          else if (rt == RI_BGEZ && !a[31]) npc = btgt;
        end
        OP_J: npc = {pc4[31:28], ins[25:0], 2'b00};
        OP_JAL: begin
          wr = 1; wi = 5'd31; wv = pc4;
          npc = {pc4[31:28], ins[25:0], 2'b00};
        end
        OP_BEQ: if (a == b) npc = btgt;
        OP_BNE: if (a != b) npc = btgt;
        OP_BLEZ: if (a[31] || a == 0) npc = btgt;
        OP_BGTZ: if (!a[31] && a != 0) npc = btgt;
        OP_ADDIU: begin wr = 1; wi = rt; wv = a + sx16(ins[15:0]); end
        OP_SLTI: begin
          wr = 1; wi = rt; wv = {31'd0, $signed(a) < $signed(sx16(ins[15:0]))};
        end
        OP_SLTIU: begin wr = 1; wi = rt; wv = {31'd0, a < sx16(ins[15:0])}; end
        OP_ANDI: begin wr = 1; wi = rt; wv = a & {16'd0, ins[15:0]}; end
        OP_ORI: begin wr = 1; wi = rt; wv = a | {16'd0, ins[15:0]}; end
        OP_XORI: begin wr = 1; wi = rt; wv = a ^ {16'd0, ins[15:0]}; end
        OP_LUI: begin wr = 1; wi = rt; wv = {ins[15:0], 16'd0}; end
        OP_COP0: begin
          if (rs == CP_MF) begin wr = 1; wi = rt; wv = cp0[rd]; end
          else if (rs == CP_MT) cp0[rd] = b;
        end
        OP_LB: begin
          wv = dmem[widx] >> sh;
          wr = 1; wi = rt; wv = {{24{wv[7]}}, wv[7:0]};
        end
        OP_LW: begin wr = 1; wi = rt; wv = dmem[widx]; end
        OP_LBU: begin
          wv = dmem[widx] >> sh;
          wr = 1; wi = rt; wv = {24'd0, wv[7:0]};
        end
        OP_SB: begin
          dmem[widx] = (dmem[widx] & ~(32'hFF << sh)) | ({24'd0, b[7:0]} << sh);
          r.store_kind = STORE_BYTE;
          r.store_address = addr;
          r.store_value = {24'd0, b[7:0]};
        end
        OP_SW: begin
          dmem[widx] = b;
          r.store_kind = STORE_WORD;
          r.store_address = addr;
          r.store_value = b;
        end
        default: ;
      endcase
      if (wr && wi != 0) begin
        gpr[wi] = wv;
        r.reg_write = 1'b1;
        r.reg_index = wi;
        r.reg_value = wv;
      end
      pc = npc;
      r.next_pc = npc;
      r.hi_value = hi;
      r.lo_value = lo;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %h, got %h", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(result_t act);
      result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction next_pc %h", act.next_pc);
        mismatches++;
        return;
      end
      e = pending_results.pop_front();
      compare_field("next_pc", e.next_pc, act.next_pc);
      compare_field("reg_write", e.reg_write, act.reg_write);
      compare_field("reg_index", e.reg_index, act.reg_index);
      compare_field("reg_value", e.reg_value, act.reg_value);
      compare_field("store_kind", e.store_kind, act.store_kind);
      compare_field("store_address", e.store_address, act.store_address);
      compare_field("store_value", e.store_value, act.store_value);
      compare_field("hi_value", e.hi_value, act.hi_value);
      compare_field("lo_value", e.lo_value, act.lo_value);
    endfunction
  endclass

endpackage

// File: dv/tb.sv
module tb;
  import mie_pkg::*;
  import mie_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   recv_hold = 1'b0;

  mie_cfg_if    cfg_if ();
  mie_instr_if  instr_if ();
  mie_result_if result_if ();

  mips_integer_instruction_execute u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if.sink),
    .instr_i  (instr_if.sink),
    .result_o (result_if.source)
  );

  mips_exec_scoreboard exec_sb = new();

  always #4 clk_i = ~clk_i;

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.start_pc = '0;
    instr_if.valid = 1'b0;
    instr_if.instruction = '0;
    result_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[mips_integer_instruction_execute] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      exec_sb.check_result('{result_if.next_pc, result_if.reg_write, result_if.reg_index,
        result_if.reg_value, result_if.store_kind, result_if.store_address,
        result_if.store_value, result_if.hi_value, result_if.lo_value});
    end
    result_if.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_start_pc(logic [31:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.start_pc <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    exec_sb.write_start_pc(v);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_instruction(logic [31:0] ins);
    while ($urandom_range(99) < send_idle_pct) begin
      instr_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    instr_if.valid <= 1'b1;
    instr_if.instruction <= ins;
    do @(posedge clk_i); while (!instr_if.ready);
    exec_sb.note_instruction(ins);
  endtask

  task automatic go_idle();
    instr_if.valid <= 1'b0;
    while (exec_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] i_type(opcode_e op, int rs, int rt, logic [15:0] imm);
    return {op, rs[4:0], rt[4:0], imm};
  endfunction

  function automatic logic [31:0] r_type(int rs, int rt, int rd, int sa, funct_e fn);
    return {OP_SPECIAL, rs[4:0], rt[4:0], rd[4:0], sa[4:0], fn};
  endfunction

  // mostly valid opcodes on a few registers so values chain; some raw noise
  function automatic logic [31:0] random_instruction();
    opcode_e ops[] = '{OP_SPECIAL, OP_SPECIAL, OP_SPECIAL, OP_REGIMM, OP_J, OP_JAL, OP_BEQ,
      OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDIU, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI,
      OP_XORI, OP_LUI, OP_COP0, OP_LB, OP_LW, OP_LBU, OP_SB, OP_SW, OP_SW};
    funct_e fns[] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
      FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_ADDU, FN_SUBU, FN_AND, FN_OR,
      FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
    logic [31:0] ins;
    ins = $urandom();
    if ($urandom_range(9) == 0) return ins;
    ins[31:26] = ops[$urandom_range(ops.size() - 1)];
    if ($urandom_range(3) != 0) begin
      ins[25:21] = 5'($urandom_range(7));
      ins[20:16] = 5'($urandom_range(7));
      ins[15:11] = 5'($urandom_range(7));
    end
    if (ins[31:26] == OP_SPECIAL && $urandom_range(7) != 0)
      ins[5:0] = fns[$urandom_range(fns.size() - 1)];
    if (ins[31:26] == OP_COP0 && $urandom_range(3) != 0)
      ins[25:21] = $urandom_range(1) ? CP_MT : CP_MF;
    if (ins[31:26] == OP_REGIMM && $urandom_range(3) != 0)
      ins[20:16] = 5'($urandom_range(1));
    return ins;
  endfunction

  task automatic run_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_instruction(random_instruction());
    go_idle();
  endtask

  initial begin
    logic [31:0] directed[$];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{
      i_type(OP_LUI, 0, 1, 16'h8000), i_type(OP_ORI, 1, 1, 16'hFFFF),
      i_type(OP_ADDIU, 0, 2, 16'hFFFF), i_type(OP_ADDIU, 0, 0, 16'h1234),
      r_type(1, 2, 3, 0, FN_MULT), r_type(0, 0, 4, 0, FN_MFHI),
      r_type(0, 0, 5, 0, FN_MFLO), r_type(1, 2, 6, 31, FN_SRA),
      r_type(2, 1, 7, 0, FN_SRLV), r_type(1, 2, 8, 0, FN_SLT),
      i_type(OP_SLTIU, 0, 9, 16'hFFFF), i_type(OP_SW, 0, 1, 16'hFFFF),
      i_type(OP_SB, 0, 2, 16'h1001), i_type(OP_LB, 0, 10, 16'h1001),
      i_type(OP_LBU, 0, 11, 16'h1001), i_type(OP_LW, 0, 12, 16'h0FFC),
      i_type(OP_COP0, CP_MT, 2, 16'h6000), i_type(OP_COP0, CP_MF, 13, 16'h6000),
      i_type(OP_REGIMM, 1, RI_BLTZ, 16'h8000), i_type(OP_BGTZ, 2, 0, 16'h7FFF),
      {OP_JAL, 26'h3FFFFFF}, r_type(1, 0, 14, 0, FN_JALR),
      32'h0000000C, 32'hFFFFFFFF, i_type(OP_COP0, 5'd16, 0, 16'h0018)
    };
    foreach (directed[i]) send_instruction(directed[i]);
    go_idle();

    write_start_pc(32'hFFFF_FFFC);
    run_phase(300, 0, 0);
    write_start_pc(32'h0000_0000);
    run_phase(400, 75, 0);
    write_start_pc($urandom());
    run_phase(400, 0, 75);
    write_start_pc(32'hA000_0000);
    run_phase(400, 15, 15);

    fork
      begin
        recv_hold = 1'b1;
        repeat (200) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      run_phase(500, 0, 0);
    join

    instr_if.valid <= 1'b0;
    while (exec_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (exec_sb.mismatches == 0 && exec_sb.pending_results.size() == 0)
      $display("[mips_integer_instruction_execute] OK");
    else
      $display("[mips_integer_instruction_execute] ERROR");
    $finish;
  end
endmodule

// File: mips_integer_instruction_execute.f
+incdir+hdl
hdl/mie_pkg.sv
hdl/mie_intf.sv
hdl/mie_ram.sv
hdl/mips_integer_instruction_execute.sv
dv/mie_tb_pkg.sv
dv/tb.sv
